### src/utf8_to_display_byte_stream_unit_defines.svh
// Assertion macros shared by the UTF-8 to display byte stream unit.
`ifndef UTF8_TO_DISPLAY_BYTE_STREAM_UNIT_DEFINES_SVH
`define UTF8_TO_DISPLAY_BYTE_STREAM_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define U2D_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define U2D_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define U2D_ASSERT(lbl, clk, rstn, prop)
`define U2D_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

### src/utf8d_pkg.sv
// Types, constants and mapping functions of the UTF-8 to display byte stream unit.
package utf8d_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw = $clog2(QDepth);
  localparam int unsigned NumSlots = 4;
  localparam int unsigned NumHeld = 3;

  localparam logic [20:0] CpBom = 21'h00FEFF;
  localparam logic [20:0] CpLeftSingle = 21'h002018;
  localparam logic [20:0] CpLeftDouble = 21'h00201C;
  localparam logic [20:0] CpEnDash = 21'h002013;
  localparam logic [20:0] CpFullLowLine = 21'h00FF3F;
  localparam logic [20:0] CpC1Single = 21'h000091;
  localparam logic [20:0] CpC1Double = 21'h000093;
  localparam logic [20:0] CpC1Dash = 21'h000096;
  localparam logic [20:0] CpAsciiEnd = 21'h000080;
  localparam logic [20:0] CpLatinLo = 21'h0000A0;
  localparam logic [20:0] CpLatinHi = 21'h0000FE;

  localparam logic [7:0] CharApostrophe = 8'h27;
  localparam logic [7:0] CharQuote = 8'h22;
  localparam logic [7:0] CharDash = 8'h2D;
  localparam logic [7:0] CharUnderscore = 8'h5F;
  localparam logic [7:0] CharQuestion = 8'h3F;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_word_t;

  typedef struct packed {
    logic [7:0] display_char;
    logic       last_of_run;
  } out_word_t;

  typedef struct packed {
    logic [NumSlots-1:0]      valid;
    logic [NumSlots-1:0][7:0] chars;
  } burst_t;

  typedef struct packed {
    logic [1:0] held_count;
    logic [2:0] sequence_length;
  } front_status_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] ch;
  } map_t;

  function automatic map_t map_cp(logic [20:0] cp);
    map_t r;
    r.valid = 1'b1;
    r.ch = CharQuestion;
    if (cp == 21'd0 || cp == CpBom) begin
      r.valid = 1'b0;
    end else if (cp == CpLeftSingle || cp == CpLeftSingle + 21'd1 ||
                 cp == CpC1Single || cp == CpC1Single + 21'd1) begin
      r.ch = CharApostrophe;
    end else if (cp == CpLeftDouble || cp == CpLeftDouble + 21'd1 ||
                 cp == CpC1Double || cp == CpC1Double + 21'd1) begin
      r.ch = CharQuote;
    end else if (cp == CpEnDash || cp == CpEnDash + 21'd1 ||
                 cp == CpC1Dash || cp == CpC1Dash + 21'd1) begin
      r.ch = CharDash;
    end else if (cp == CpFullLowLine) begin
      r.ch = CharUnderscore;
    end else if (cp < CpAsciiEnd) begin
      r.ch = cp[7:0];
    end else if (cp >= CpLatinLo && cp <= CpLatinHi) begin
      r.ch = cp[7:0];
    end
    return r;
  endfunction

  function automatic logic [2:0] lead_len(logic [7:0] b);
    logic [2:0] len;
    len = 3'd1;
    if (b[7:5] == 3'b110) begin
      len = 3'd2;
    end else if (b[7:4] == 4'b1110) begin
      len = 3'd3;
    end else if (b[7:3] == 5'b11110) begin
      len = 3'd4;
    end
    return len;
  endfunction

endpackage

### src/utf8d_front.sv
// Front end: holds a started sequence, decodes it and forms the burst of output characters.
module utf8d_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  utf8d_pkg::in_word_t      in_word_i,
  output logic                     burst_valid_o,
  output utf8d_pkg::burst_t        burst_o,
  output utf8d_pkg::front_status_t status_o
);

  logic [7:0]  held_q [utf8d_pkg::NumHeld];
  logic [1:0]  cnt_q, cnt_d;
  logic [2:0]  seq_q, seq_d;
  logic        hold_we;
  logic [1:0]  hold_idx;

  logic [7:0]  b;
  logic        eot;
  logic        is_cont;
  logic [2:0]  len;
  logic        seq_active;
  logic        weird;
  logic        case_cont;
  logic        complete;
  logic        append;
  logic        overflow;
  logic        fresh;
  logic        is_lead;
  logic        prefix_en;
  logic        tail_en;
  logic [20:0] cp;
  logic [20:0] tail_cp;
  utf8d_pkg::map_t tail_map;
  utf8d_pkg::map_t held_map [utf8d_pkg::NumHeld];

  always_comb begin
    b = in_word_i.text_byte;
    eot = in_word_i.end_of_text;
    is_cont = (b[7:6] == 2'b10);
    len = utf8d_pkg::lead_len(b);
    is_lead = (len >= 3'd2);
    seq_active = (seq_q != 3'd0);
    weird = (cnt_q == 2'd0) || (seq_q > 3'd4);
    case_cont = seq_active && !weird && is_cont;
    complete = case_cont && (({1'b0, cnt_q} + 3'd1) == seq_q);
    append = case_cont && !complete && (cnt_q < 2'd3);
    overflow = case_cont && !complete && !append;
    fresh = !case_cont;
    prefix_en = (append && eot) || overflow || (fresh && seq_active);
    tail_en = complete || (append && eot) || overflow || (fresh && !(is_lead && !eot));

    case (seq_q)
      3'd2: cp = {10'd0, held_q[0][4:0], b[5:0]};
      3'd3: cp = {5'd0, held_q[0][3:0], held_q[1][5:0], b[5:0]};
      default: cp = {held_q[0][2:0], held_q[1][5:0], held_q[2][5:0], b[5:0]};
    endcase
    tail_cp = complete ? cp : {13'd0, b};
    tail_map = utf8d_pkg::map_cp(tail_cp);

    for (int i = 0; i < utf8d_pkg::NumHeld; i++) begin
      held_map[i] = utf8d_pkg::map_cp({13'd0, held_q[i]});
      burst_o.valid[i] = prefix_en && (cnt_q > 2'(i)) && held_map[i].valid;
      burst_o.chars[i] = held_map[i].ch;
    end
    burst_o.valid[utf8d_pkg::NumSlots-1] = tail_en && tail_map.valid;
    burst_o.chars[utf8d_pkg::NumSlots-1] = tail_map.ch;
    burst_valid_o = accept_i && (burst_o.valid != '0);

    cnt_d = cnt_q;
    seq_d = seq_q;
    hold_we = 1'b0;
    hold_idx = cnt_q;
    if (complete || overflow) begin
      cnt_d = 2'd0;
      seq_d = 3'd0;
    end else if (append) begin
      hold_we = 1'b1;
      cnt_d = cnt_q + 2'd1;
    end else if (is_lead) begin
      hold_we = 1'b1;
      hold_idx = 2'd0;
      cnt_d = 2'd1;
      seq_d = len;
    end else begin
      cnt_d = 2'd0;
      seq_d = 3'd0;
    end
    if (eot) begin
      cnt_d = 2'd0;
      seq_d = 3'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      seq_q <= 3'd0;
    end else if (accept_i) begin
      cnt_q <= cnt_d;
      seq_q <= seq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < utf8d_pkg::NumHeld; i++) begin
      if (accept_i && hold_we && (hold_idx == 2'(i))) begin
        held_q[i] <= b;
      end
    end
  end

  assign status_o.held_count = cnt_q;
  assign status_o.sequence_length = seq_q;

endmodule

### src/utf8d_fifo.sv
// Short queue of character bursts between the front end and the back end.
module utf8d_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  utf8d_pkg::burst_t wr_data_i,
  output logic              full_o,
  input  logic              rd_en_i,
  output utf8d_pkg::burst_t rd_data_o,
  output logic              empty_o
);

  utf8d_pkg::burst_t mem_q [utf8d_pkg::QDepth];
  logic [utf8d_pkg::QAw-1:0] wr_ptr_q;
  logic [utf8d_pkg::QAw-1:0] rd_ptr_q;
  logic [utf8d_pkg::QAw:0]   cnt_q;
  logic                      do_wr;
  logic                      do_rd;

  assign full_o = (cnt_q == (utf8d_pkg::QAw+1)'(utf8d_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign do_wr = wr_en_i && !full_o;
  assign do_rd = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

### src/utf8d_back.sv
// Back end: holds one burst and hands out its characters one word at a time.
module utf8d_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fifo_empty_i,
  input  utf8d_pkg::burst_t    fifo_data_i,
  output logic                 fifo_pop_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output utf8d_pkg::out_word_t data_o
);

  logic [utf8d_pkg::NumSlots-1:0]      mask_q, mask_d;
  logic [utf8d_pkg::NumSlots-1:0][7:0] chars_q;
  logic [1:0]                          idx;
  logic [utf8d_pkg::NumSlots-1:0]      rest;
  logic                                last;
  logic                                take;
  logic                                load;

  always_comb begin
    idx = 2'd0;
    for (int i = utf8d_pkg::NumSlots - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        idx = 2'(i);
      end
    end
    rest = mask_q & ~(utf8d_pkg::NumSlots'(1) << idx);
    last = (rest == '0);
    empty_o = (mask_q == '0);
    take = pop_i && !empty_o;
    load = (empty_o || (take && last)) && !fifo_empty_i;
    fifo_pop_o = load;
    data_o.display_char = chars_q[idx];
    data_o.last_of_run = last;
    if (load) begin
      mask_d = fifo_data_i.valid;
    end else if (take) begin
      mask_d = rest;
    end else begin
      mask_d = mask_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      chars_q <= fifo_data_i.chars;
    end
  end

endmodule

### src/utf8_to_display_byte_stream_unit.sv
// Top level of the UTF-8 to display byte stream unit.
//
//   Channel   Direction  Handshake            Word
//   input     in         push / full          data_i  (text_byte, end_of_text)
//   result    out        empty / pop          data_o  (display_char, last_of_run)
//
// An input byte is taken in the cycle it is pushed and may be followed by another
// in the next cycle while the burst queue has room.
// Each byte gives zero to four characters, which leave one per cycle from the back end while pop is held;
// the first is written into the burst queue, then loaded into the back end, before it reaches the result ports.
// A byte that gives no character reaches no queue entry.
// Reset clears the held sequence, the queue pointers and the back end.
// A stalled result side fills the four-entry queue, after which full is raised.
`include "utf8_to_display_byte_stream_unit_defines.svh"

module utf8_to_display_byte_stream_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  utf8d_pkg::in_word_t  data_i,
  output logic                 empty,
  input  logic                 pop,
  output utf8d_pkg::out_word_t data_o
);

  logic                     accept;
  logic                     burst_valid;
  utf8d_pkg::burst_t        burst;
  utf8d_pkg::front_status_t front_status;
  logic                     fifo_empty;
  logic                     fifo_pop;
  utf8d_pkg::burst_t        fifo_data;
  logic                     eot_taken;
  logic                     front_clear;
  logic                     run_going;
  logic                     refill_due;
  logic                     held_overrun;

  assign accept = push && !full;

  utf8d_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .in_word_i    (data_i),
    .burst_valid_o(burst_valid),
    .burst_o      (burst),
    .status_o     (front_status)
  );

  utf8d_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (burst_valid),
    .wr_data_i(burst),
    .full_o   (full),
    .rd_en_i  (fifo_pop),
    .rd_data_o(fifo_data),
    .empty_o  (fifo_empty)
  );

  utf8d_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fifo_empty_i(fifo_empty),
    .fifo_data_i (fifo_data),
    .fifo_pop_o  (fifo_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .data_o      (data_o)
  );

  assign eot_taken = accept && data_i.end_of_text;
  assign front_clear = (front_status.held_count == 2'd0) &&
                       (front_status.sequence_length == 3'd0);
  assign run_going = pop && !empty && !data_o.last_of_run;
  assign refill_due = !fifo_empty && (empty || (pop && data_o.last_of_run));
  assign held_overrun = (front_status.sequence_length != 3'd0) &&
                        (3'(front_status.held_count) >= front_status.sequence_length);

  `U2D_ASSERT(a_eot_clears_held, clk_i, rst_ni, eot_taken |=> front_clear)
  `U2D_ASSERT(a_run_continues, clk_i, rst_ni, run_going |=> !empty)
  `U2D_ASSERT(a_back_refills, clk_i, rst_ni, refill_due |=> !empty)
  `U2D_ASSERT_NEVER(a_held_in_range, clk_i, rst_ni, held_overrun)

endmodule

### bench/utf8_display_checker.sv
// Checker that predicts the display characters of the UTF-8 unit and compares every popped word.
module utf8_display_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  input  logic                 full,
  input  utf8d_pkg::in_word_t  data_i,
  input  logic                 empty,
  input  logic                 pop,
  input  utf8d_pkg::out_word_t data_o,
  output int                   fail_count,
  output int                   pending_count
);

  logic [7:0]           held_bytes [3];
  logic [1:0]           held_cnt;
  logic [2:0]           seq_len;
  utf8d_pkg::out_word_t run_chars[$];
  utf8d_pkg::out_word_t expected_chars[$];
  utf8d_pkg::out_word_t want;
  int                   mismatches;

  function automatic void emit_code_point(logic [20:0] cp);
    utf8d_pkg::out_word_t w;
    w.last_of_run = 1'b0;
    if (cp == 21'd0 || cp == utf8d_pkg::CpBom ||
        run_chars.size() >= utf8d_pkg::NumSlots) begin
      return;
    end
    if (cp inside {utf8d_pkg::CpLeftSingle, utf8d_pkg::CpLeftSingle + 21'd1,
                   utf8d_pkg::CpC1Single, utf8d_pkg::CpC1Single + 21'd1}) begin
      w.display_char = utf8d_pkg::CharApostrophe;
    end else if (cp inside {utf8d_pkg::CpLeftDouble, utf8d_pkg::CpLeftDouble + 21'd1,
                            utf8d_pkg::CpC1Double, utf8d_pkg::CpC1Double + 21'd1}) begin
      w.display_char = utf8d_pkg::CharQuote;
    end else if (cp inside {utf8d_pkg::CpEnDash, utf8d_pkg::CpEnDash + 21'd1,
                            utf8d_pkg::CpC1Dash, utf8d_pkg::CpC1Dash + 21'd1}) begin
      w.display_char = utf8d_pkg::CharDash;
    end else if (cp == utf8d_pkg::CpFullLowLine) begin
      w.display_char = utf8d_pkg::CharUnderscore;
    end else if (cp < utf8d_pkg::CpAsciiEnd ||
                 (cp >= utf8d_pkg::CpLatinLo && cp <= utf8d_pkg::CpLatinHi)) begin
      w.display_char = cp[7:0];
    end else begin
      w.display_char = utf8d_pkg::CharQuestion;
    end
    run_chars.push_back(w);
  endfunction

  function automatic void flush_held();
    for (int i = 0; i < held_cnt; i++) begin
      emit_code_point({13'd0, held_bytes[i]});
    end
    held_cnt = 2'd0;
    seq_len = 3'd0;
  endfunction

  function automatic void decode_word(utf8d_pkg::in_word_t w);
    logic [7:0]  b;
    logic        fresh;
    logic [20:0] cp;
    b = w.text_byte;
    fresh = 1'b1;
    run_chars.delete();
    if (seq_len != 3'd0) begin
      if (b[7:6] == 2'b10) begin
        fresh = 1'b0;
        if ({1'b0, held_cnt} + 3'd1 == seq_len) begin
          case (seq_len)
            3'd2: cp = {16'd0, held_bytes[0][4:0]};
            3'd3: cp = {17'd0, held_bytes[0][3:0]};
            default: cp = {18'd0, held_bytes[0][2:0]};
          endcase
          for (int i = 1; i < held_cnt; i++) begin
            cp = {cp[14:0], held_bytes[i][5:0]};
          end
          cp = {cp[14:0], b[5:0]};
          held_cnt = 2'd0;
          seq_len = 3'd0;
          emit_code_point(cp);
        end else begin
          held_bytes[held_cnt] = b;
          held_cnt = held_cnt + 2'd1;
        end
      end else begin
        flush_held();
      end
    end
    if (fresh) begin
      if (b[7:5] == 3'b110) begin
        seq_len = 3'd2;
      end else if (b[7:4] == 4'b1110) begin
        seq_len = 3'd3;
      end else if (b[7:3] == 5'b11110) begin
        seq_len = 3'd4;
      end
      if (seq_len != 3'd0) begin
        held_bytes[0] = b;
        held_cnt = 2'd1;
      end else begin
        emit_code_point({13'd0, b});
      end
    end
    if (w.end_of_text) begin
      flush_held();
    end
    if (run_chars.size() > 0) begin
      run_chars[run_chars.size() - 1].last_of_run = 1'b1;
    end
    foreach (run_chars[i]) begin
      expected_chars.push_back(run_chars[i]);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_cnt = 2'd0;
      seq_len = 3'd0;
      expected_chars.delete();
      mismatches = 0;
      fail_count <= 0;
      pending_count <= 0;
    end else begin
      if (pop && !empty) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected result word: display_char 0x%02h, last_of_run %0b",
                 data_o.display_char, data_o.last_of_run);
          mismatches++;
        end else begin
          want = expected_chars.pop_front();
          if (data_o.display_char !== want.display_char) begin
            $error("display_char mismatch: expected 0x%02h, actual 0x%02h",
                   want.display_char, data_o.display_char);
            mismatches++;
          end
          if (data_o.last_of_run !== want.last_of_run) begin
            $error("last_of_run mismatch: expected %0b, actual %0b",
                   want.last_of_run, data_o.last_of_run);
            mismatches++;
          end
        end
      end
      if (push && !full) begin
        decode_word(data_i);
      end
      fail_count <= mismatches;
      pending_count <= expected_chars.size();
    end
  end

endmodule

### bench/utf8_to_display_byte_stream_unit_tb.sv
// Testbench top that feeds UTF-8 text words to the unit and gives the verdict.
module utf8_to_display_byte_stream_unit_tb;

  localparam int WatchdogLimit = 2000;
  localparam int TextLength = 470;
  localparam int QuietTail = 60;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 push = 1'b0;
  logic                 pop = 1'b0;
  utf8d_pkg::in_word_t  data_i = '0;
  logic                 full;
  logic                 empty;
  utf8d_pkg::out_word_t data_o;
  int                   fail_count;
  int                   pending_count;
  int                   stall_cycles = 0;
  logic                 quiet = 1'b0;

  utf8d_pkg::in_word_t text_words[$];
  logic [8:0]  opening_bytes[$] = '{
    9'h000, 9'h07F, 9'h080, 9'h0FF,
    9'h0E2, 9'h080, 9'h09D,
    9'h0EF, 9'h0BB, 9'h0BF,
    9'h0EF, 9'h0BC, 9'h0BF,
    9'h0C2, 9'h096,
    9'h0C3, 9'h0BF,
    9'h0F0, 9'h090, 9'h080, 9'h041,
    9'h0E2, 9'h180,
    9'h0F0, 9'h090, 9'h080, 9'h1C3,
    9'h1FE
  };
  logic [20:0] notable_cps[$] = '{
    utf8d_pkg::CpLeftSingle, utf8d_pkg::CpLeftSingle + 21'd1,
    utf8d_pkg::CpLeftDouble, utf8d_pkg::CpLeftDouble + 21'd1,
    utf8d_pkg::CpEnDash, utf8d_pkg::CpEnDash + 21'd1,
    utf8d_pkg::CpFullLowLine, utf8d_pkg::CpBom,
    utf8d_pkg::CpC1Single, utf8d_pkg::CpC1Single + 21'd1,
    utf8d_pkg::CpC1Double, utf8d_pkg::CpC1Double + 21'd1,
    utf8d_pkg::CpC1Dash, utf8d_pkg::CpC1Dash + 21'd1, 21'h000000, 21'h00007F,
    21'h000080, 21'h00009F, 21'h0000A0, 21'h0000FE, 21'h0000FF
  };

  utf8_to_display_byte_stream_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push   (push),
    .full   (full),
    .data_i (data_i),
    .empty  (empty),
    .pop    (pop),
    .data_o (data_o)
  );

  utf8_display_checker char_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .data_i        (data_i),
    .empty         (empty),
    .pop           (pop),
    .data_o        (data_o),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic text_ends();
    return $urandom_range(0, 19) == 0;
  endfunction

  function automatic void add_byte(logic [7:0] b, logic eot);
    utf8d_pkg::in_word_t w;
    w.text_byte = b;
    w.end_of_text = eot;
    text_words.push_back(w);
  endfunction

  function automatic void add_code_point(logic [20:0] cp, int len);
    case (len)
      1: add_byte({1'b0, cp[6:0]}, text_ends());
      2: add_byte({3'b110, cp[10:6]}, text_ends());
      3: add_byte({4'b1110, cp[15:12]}, text_ends());
      default: begin
        add_byte({5'b11110, cp[20:18]}, text_ends());
        add_byte({2'b10, cp[17:12]}, text_ends());
      end
    endcase
    if (len >= 3) begin
      add_byte({2'b10, cp[11:6]}, text_ends());
    end
    if (len >= 2) begin
      add_byte({2'b10, cp[5:0]}, text_ends());
    end
  endfunction

  function automatic void add_random_text();
    int          kind;
    int          len;
    logic [20:0] cp;
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      if ($urandom_range(0, 3) == 0) begin
        cp = notable_cps[$urandom_range(0, notable_cps.size() - 1)];
        len = (cp < 21'h80) ? 1 : (cp < 21'h800) ? 2 : 3;
        if ($urandom_range(0, 4) == 0) begin
          len = len + 1;
        end
      end else begin
        cp = 21'($urandom());
        len = $urandom_range(1, 4);
      end
      add_code_point(cp, len);
    end else if (kind < 80) begin
      add_byte(8'($urandom_range(0, 255)), text_ends());
    end else if (kind < 95) begin
      len = $urandom_range(2, 4);
      case (len)
        2: add_byte({3'b110, 5'($urandom())}, text_ends());
        3: add_byte({4'b1110, 4'($urandom())}, text_ends());
        default: add_byte({5'b11110, 3'($urandom())}, text_ends());
      endcase
      repeat ($urandom_range(0, len - 2)) begin
        add_byte({2'b10, 6'($urandom())}, text_ends());
      end
      if ($urandom_range(0, 1) == 0) begin
        add_byte({1'b0, 7'($urandom())}, text_ends());
      end else begin
        add_byte({2'b11, 6'($urandom())}, text_ends());
      end
    end else begin
      repeat ($urandom_range(1, 3)) begin
        add_byte({2'b10, 6'($urandom())}, text_ends());
      end
    end
  endfunction

  initial begin
    foreach (opening_bytes[i]) begin
      add_byte(opening_bytes[i][7:0], opening_bytes[i][8]);
    end
    while (text_words.size() < TextLength) begin
      add_random_text();
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int idx = 0; idx < text_words.size(); idx++) begin
      quiet = (idx + QuietTail >= text_words.size());
      if (!quiet && $urandom_range(0, 7) == 0) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end
      push <= 1'b1;
      data_i <= text_words[idx];
      @(posedge clk_i);
      while (full) @(posedge clk_i);
    end
    push <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    wait (rst_ni);
    forever begin
      if (!quiet && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WatchdogLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

endmodule
